// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files of the page frame allocator.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pfa_pkg.sv -----
// Shared types and constants of the page frame allocator.
// No dependencies; imported by every module of the block except pfa_fifo.
package pfa_pkg;

    localparam int ACT_W     = 2;
    localparam int PAGE_W    = 14;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 1;
    localparam int REF_W     = 8;

    // Depth of the link and count memories; the page fields are sized to match.
    localparam int MAX_PAGES = 16384;

    // Low memory ends at 640 KiB; the trampoline sits at 32 KiB; 4 KiB pages.
    localparam int PAGE_SHIFT      = 12;
    localparam int LOW_MEM_BYTES   = 32'h000A_0000;
    localparam int TRAMP_BYTES     = 32'h0000_8000;
    localparam int LOW_MEM_PAGES   = LOW_MEM_BYTES >> PAGE_SHIFT;
    localparam int TRAMPOLINE_PAGE = TRAMP_BYTES >> PAGE_SHIFT;

    localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNREF = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END  = 1'd1;

    localparam logic [CFG_W-1:0] TOTAL_PAGES_RST = 15'd16384;
    localparam logic [CFG_W-1:0] KERNEL_END_RST  = 15'd1024;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PAGE_W-1:0] page_index;
    } in_item_t;

    typedef struct packed {
        logic [PAGE_W-1:0] result_page;
        logic [STAT_W-1:0] status;
        logic              became_free;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_NOP      = 3'd0,
        CMD_INIT     = 3'd1,
        CMD_ALLOC    = 3'd2,
        CMD_FREE     = 3'd3,
        CMD_BAD_FREE = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [PAGE_W-1:0] page_index;
    } cmd_t;

endpackage

// ----- rtl/core/page_frame_free_list_allocator.sv -----
// Page frame allocator top level: configuration registers and queue wiring.
// Depends on pfa_pkg, pfa_fifo, pfa_front and pfa_back.
//
// Requests enter through a queue-style port: a transaction is taken on a clock
// edge with push high and full low. Results leave the same way: the oldest
// result is shown while empty is low and is taken on an edge with pop high.
// Every request yields exactly one result, in request order.
// An allocate or free request passes the command queue, then the registered
// read of the link and count memories, then the write-back, before its result
// is queued; the back end takes no new command until that write-back is done.
// Init sweeps every page once, one page a cycle; a free of an out-of-range page
// or an unknown action is answered from the idle state without a memory access.
// After reset the free list is empty and the counts are undefined: issue an
// init before any allocate or free. If pop stays low, two results wait in the
// result queue, then two requests in the command queue, and full rises.
// Configuration writes (cfg_we, cfg_idx, cfg_wdata) take effect at once and
// must only be issued while no request is outstanding.
module page_frame_free_list_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  pfa_pkg::in_item_t             in_item,
    output logic                          empty,
    input  logic                          pop,
    output pfa_pkg::out_item_t            out_item,
    input  logic                          cfg_we,
    input  logic [pfa_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [pfa_pkg::CFG_W-1:0]     cfg_wdata
);
    import pfa_pkg::*;

    logic [CFG_W-1:0] total_pages_reg, total_pages_next;
    logic [CFG_W-1:0] kernel_end_reg, kernel_end_next;

    logic      cmd_valid;
    logic      cmd_pop;
    cmd_t      cmd;
    logic      res_full;
    logic      res_push;
    out_item_t res_item;
    logic [$bits(out_item_t)-1:0] res_raw;

    always_comb
    begin
        total_pages_next = total_pages_reg;
        kernel_end_next  = kernel_end_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_TOTAL_PAGES: total_pages_next = cfg_wdata;
                CFG_KERNEL_END:  kernel_end_next  = cfg_wdata;
                default:         total_pages_next = total_pages_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pages_reg <= TOTAL_PAGES_RST;
            kernel_end_reg  <= KERNEL_END_RST;
        end
        else
        begin
            total_pages_reg <= total_pages_next;
            kernel_end_reg  <= kernel_end_next;
        end
    end

    pfa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_item     (in_item),
        .total_pages (total_pages_reg),
        .cmd_pop     (cmd_pop),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    pfa_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .total_pages     (total_pages_reg),
        .kernel_end_page (kernel_end_reg),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .res_full        (res_full),
        .res_push        (res_push),
        .res_item        (res_item)
    );

    pfa_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_item),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_raw),
        .empty   (empty)
    );

    assign out_item = out_item_t'(res_raw);

endmodule

// ----- rtl/core/pfa_fifo.sv -----
// Small synchronous FIFO used for the command and result queues.
// No package dependency; width and depth come from parameters.
module pfa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/pfa_front.sv -----
// Front end: accepts request transactions, classifies them and queues commands.
// Depends on pfa_pkg and pfa_fifo.
module pfa_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  pfa_pkg::in_item_t           in_item,
    input  logic [pfa_pkg::CFG_W-1:0]   total_pages,
    input  logic                        cmd_pop,
    output logic                        cmd_valid,
    output pfa_pkg::cmd_t               cmd
);
    import pfa_pkg::*;

    localparam int PW = $clog2(MAX_PAGES);
    localparam int CW = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;

    logic [CW-1:0]       lim;
    logic                in_range;
    cmd_t                cmd_in;
    logic                cmd_empty;
    logic [$bits(cmd_t)-1:0] cmd_raw;

    // Only pages below the smaller of total_pages and the memory depth exist.
    assign lim      = (CW'(total_pages) < CW'(MAX_PAGES)) ? CW'(total_pages) : CW'(MAX_PAGES);
    assign in_range = CW'(in_item.page_index) < lim;

    always_comb
    begin
        cmd_in.page_index = in_item.page_index;
        case (in_item.action)
            ACT_INIT:  cmd_in.kind = CMD_INIT;
            ACT_ALLOC: cmd_in.kind = CMD_ALLOC;
            ACT_FREE:  cmd_in.kind = in_range ? CMD_FREE : CMD_BAD_FREE;
            default:   cmd_in.kind = CMD_NOP;
        endcase
    end

    pfa_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_raw),
        .empty   (cmd_empty)
    );

    assign cmd_valid = !cmd_empty;
    assign cmd       = cmd_t'(cmd_raw);

endmodule

// ----- rtl/core/pfa_back.sv -----
// Back end: executes commands against the link and reference count memories.
// Depends on pfa_pkg; holds the free list head and the init sweep sequencer.
module pfa_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pfa_pkg::CFG_W-1:0] total_pages,
    input  logic [pfa_pkg::CFG_W-1:0] kernel_end_page,
    input  logic                      cmd_valid,
    input  pfa_pkg::cmd_t             cmd,
    output logic                      cmd_pop,
    input  logic                      res_full,
    output logic                      res_push,
    output pfa_pkg::out_item_t        res_item
);
    import pfa_pkg::*;

    localparam int PW = $clog2(MAX_PAGES);
    localparam int LW = PW + 1;
    localparam int CW = (LW > CFG_W) ? LW : CFG_W;
    localparam logic [LW-1:0] LIST_END  = LW'(MAX_PAGES);
    localparam logic [PW-1:0] LAST_PAGE = PW'(MAX_PAGES - 1);
    localparam logic [CW-1:0] C_LOW     = CW'(LOW_MEM_PAGES);
    localparam logic [CW-1:0] C_TRAMP   = CW'(TRAMPOLINE_PAGE);
    localparam logic [CW-1:0] C_TRAMP1  = CW'(TRAMPOLINE_PAGE + 1);
    localparam logic [CW-1:0] C_ONE     = CW'(1);
    localparam logic [CW-1:0] C_END     = CW'(MAX_PAGES);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_INIT = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [LW-1:0]   head_reg, head_next;
    cmd_t            cmd_reg, cmd_next;
    logic [PW-1:0]   idx_reg, idx_next;

    logic [LW-1:0]    link_mem [MAX_PAGES];
    logic [REF_W-1:0] ref_mem [MAX_PAGES];
    logic [LW-1:0]    link_rd_reg;
    logic [REF_W-1:0] ref_rd_reg;

    logic             rd_en;
    logic             link_we;
    logic [PW-1:0]    link_waddr;
    logic [LW-1:0]    link_wdata;
    logic             ref_we;
    logic [PW-1:0]    ref_waddr;
    logic [REF_W-1:0] ref_wdata;
    logic [REF_W-1:0] ref_dec;

    // Free list layout from the current configuration.
    logic [CW-1:0] lim, start_c, end_a, end_b;
    logic [CW-1:0] head_a, head_b, head_c;
    logic [CW-1:0] pg_i, pg_inc, sweep_link;
    logic          in_a, in_b, in_c;

    always_comb
    begin
        lim     = (CW'(total_pages) < C_END) ? CW'(total_pages) : C_END;
        start_c = (CW'(kernel_end_page) > C_LOW) ? CW'(kernel_end_page) : C_LOW;
        end_a   = (C_LOW < lim) ? C_LOW : lim;
        end_b   = (C_TRAMP < lim) ? C_TRAMP : lim;
        head_c  = (start_c < lim) ? start_c : C_END;
        head_b  = (C_ONE < end_b) ? C_ONE : head_c;
        head_a  = (C_TRAMP1 < end_a) ? C_TRAMP1 : head_b;

        pg_i   = CW'(idx_reg);
        pg_inc = pg_i + C_ONE;
        in_a   = (pg_i >= C_TRAMP1) && (pg_i < end_a);
        in_b   = (pg_i >= C_ONE) && (pg_i < end_b);
        in_c   = (pg_i >= start_c) && (pg_i < lim);

        // The last page of each run links to the first page of the next run.
        if (in_a)
        begin
            sweep_link = (pg_inc < end_a) ? pg_inc : head_b;
        end
        else if (in_b)
        begin
            sweep_link = (pg_inc < end_b) ? pg_inc : head_c;
        end
        else if (in_c)
        begin
            sweep_link = (pg_inc < lim) ? pg_inc : C_END;
        end
        else
        begin
            sweep_link = C_END;
        end
    end

    assign ref_dec = ref_rd_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        cmd_pop    = 1'b0;
        rd_en      = 1'b0;
        res_push   = 1'b0;
        res_item   = '0;
        link_we    = 1'b0;
        link_waddr = PW'(cmd_reg.page_index);
        link_wdata = head_reg;
        ref_we     = 1'b0;
        ref_waddr  = PW'(cmd_reg.page_index);
        ref_wdata  = ref_dec;

        case (state_reg)
            S_IDLE:
            begin
                // Space in the result queue now stays until this command pushes.
                if (cmd_valid && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    case (cmd.kind)
                        CMD_INIT:
                        begin
                            idx_next   = '0;
                            head_next  = LW'(head_a);
                            state_next = S_INIT;
                        end
                        CMD_ALLOC, CMD_FREE:
                        begin
                            rd_en      = 1'b1;
                            state_next = S_EXEC;
                        end
                        CMD_BAD_FREE:
                        begin
                            res_push        = 1'b1;
                            res_item.status = ST_UNREF;
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end

            S_EXEC:
            begin
                res_push   = 1'b1;
                state_next = S_IDLE;
                case (cmd_reg.kind)
                    CMD_ALLOC:
                    begin
                        if (head_reg < LIST_END)
                        begin
                            res_item.result_page = PAGE_W'(head_reg);
                            ref_we    = 1'b1;
                            ref_waddr = head_reg[PW-1:0];
                            ref_wdata = REF_W'(1);
                            head_next = (link_rd_reg > LIST_END) ? LIST_END : link_rd_reg;
                        end
                        else
                        begin
                            res_item.status = ST_EMPTY;
                            head_next       = LIST_END;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (ref_rd_reg == '0)
                        begin
                            res_item.status = ST_UNREF;
                        end
                        else
                        begin
                            ref_we = 1'b1;
                            if (ref_dec == '0)
                            begin
                                link_we              = 1'b1;
                                head_next            = LW'(cmd_reg.page_index);
                                res_item.became_free = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        res_item = '0;
                    end
                endcase
            end

            S_INIT:
            begin
                ref_we     = 1'b1;
                ref_waddr  = idx_reg;
                ref_wdata  = (in_a || in_b || in_c) ? '0 : REF_W'(1);
                link_we    = 1'b1;
                link_waddr = idx_reg;
                link_wdata = LW'(sweep_link);
                if (idx_reg == LAST_PAGE)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= LIST_END;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            link_rd_reg <= link_mem[head_reg[PW-1:0]];
            ref_rd_reg  <= ref_mem[PW'(cmd.page_index)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_waddr] <= ref_wdata;
        end
    end

endmodule

// ----- rtl/core/pfa_checker.sv -----
// Port-level checker for the page frame allocator, bound to the top level.
// Depends on pfa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pfa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input pfa_pkg::out_item_t  out_item
);
    import pfa_pkg::*;

    // A page returned to the list is never reported with an error or a page.
    `PFA_ASSERT_IMP(a_freed_clean, clk, rst_n, !empty && out_item.became_free, out_item.status == ST_OK && out_item.result_page == '0, "freed result carries error or page")

    // Failed transactions carry no page and no freed flag.
    `PFA_ASSERT_IMP(a_error_clean, clk, rst_n, !empty && out_item.status != ST_OK, out_item.result_page == '0 && !out_item.became_free, "error result carries payload")

    // A waiting result stays until it is popped.
    `PFA_ASSERT_NXT(a_result_held, clk, rst_n, !empty && !pop, !empty, "waiting result dropped")

    `PFA_ASSERT_NXT(a_result_stable, clk, rst_n, !empty && !pop, $stable(out_item), "waiting result changed")

endmodule

bind page_frame_free_list_allocator pfa_checker u_pfa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);

// ----- test/page_frame_free_list_allocator_tb.sv -----
// Self-checking testbench for the page frame allocator: directed script, then random phases.
// Depends on pfa_pkg and page_frame_free_list_allocator; results are checked against a
// behavioral free-list and reference-count predictor kept in this file.
module page_frame_free_list_allocator_tb;
    import pfa_pkg::*;

    localparam logic [CFG_W-1:0] LIST_END = CFG_W'(MAX_PAGES);
    localparam logic [ACT_W-1:0] ACT_UNDEF = 2'd3;
    localparam int PHASES = 7;
    localparam int ITEMS_PER_PHASE = 183;

    typedef enum int {SINK_STREAM, SINK_COIN, SINK_STARVE, SINK_PERIODIC} sink_mode_t;

    typedef struct packed {
        bit                   reg_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        in_item_t             req;
        bit                   typed;
        out_item_t            want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    in_item_t             in_item;
    logic                 empty;
    logic                 pop;
    out_item_t            out_item;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_wdata;

    // Shadow copy of the allocator state and its configuration.
    logic [CFG_W-1:0] shadow_head;
    logic [CFG_W-1:0] shadow_link [MAX_PAGES];
    logic [REF_W-1:0] shadow_refs [MAX_PAGES];
    logic [CFG_W-1:0] cfg_total;
    logic [CFG_W-1:0] cfg_kend;

    out_item_t   awaited_outcomes [$];
    int unsigned held_pages [$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned requests_sent = 0;
    int unsigned init_count = 0;
    int unsigned empty_allocs = 0;
    int unsigned bad_frees = 0;
    int unsigned pages_returned = 0;

    always #4 clk = ~clk;

    page_frame_free_list_allocator dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .in_item(in_item),
        .empty(empty),
        .pop(pop),
        .out_item(out_item),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_wdata(cfg_wdata)
    );

    function automatic int unsigned managed_pages();
        return (cfg_total < MAX_PAGES) ? cfg_total : MAX_PAGES;
    endfunction

    function automatic out_item_t allocator_outcome(in_item_t req);
        out_item_t   rsp;
        int unsigned lim;
        int unsigned first_high;
        int unsigned pg;
        int unsigned i;
        int unsigned chain [$];
        rsp = '0;
        lim = managed_pages();
        pg = req.page_index;
        case (req.action)
            ACT_INIT:
            begin
                for (i = 0; i < MAX_PAGES; i++)
                begin
                    shadow_link[i] = LIST_END;
                    shadow_refs[i] = REF_W'(1);
                end
                // Head order: above the trampoline, below it, then above the kernel image.
                for (i = TRAMPOLINE_PAGE + 1; i < LOW_MEM_PAGES && i < lim; i++)
                    chain.push_back(i);
                for (i = 1; i < TRAMPOLINE_PAGE && i < lim; i++)
                    chain.push_back(i);
                first_high = (cfg_kend > LOW_MEM_PAGES) ? cfg_kend : LOW_MEM_PAGES;
                for (i = first_high; i < lim; i++)
                    chain.push_back(i);
                // Building from the tail backward leaves the head at the first page.
                shadow_head = LIST_END;
                for (i = chain.size(); i > 0; i--)
                begin
                    shadow_link[chain[i-1]] = shadow_head;
                    shadow_refs[chain[i-1]] = '0;
                    shadow_head = CFG_W'(chain[i-1]);
                end
            end
            ACT_ALLOC:
            begin
                if (shadow_head < LIST_END)
                begin
                    rsp.result_page = shadow_head[PAGE_W-1:0];
                    shadow_refs[shadow_head] = REF_W'(1);
                    shadow_head = shadow_link[shadow_head];
                end
                else
                    rsp.status = ST_EMPTY;
            end
            ACT_FREE:
            begin
                if (pg >= lim || shadow_refs[pg] == 0)
                    rsp.status = ST_UNREF;
                else
                begin
                    shadow_refs[pg] = shadow_refs[pg] - 1'b1;
                    if (shadow_refs[pg] == 0)
                    begin
                        shadow_link[pg] = shadow_head;
                        shadow_head = CFG_W'(pg);
                        rsp.became_free = 1'b1;
                    end
                end
            end
            default:
                ;
        endcase
        return rsp;
    endfunction

    function automatic dir_row_t req_row(logic [ACT_W-1:0] act, int unsigned pg);
        dir_row_t row;
        row = '0;
        row.req.action = act;
        row.req.page_index = PAGE_W'(pg);
        return row;
    endfunction

    function automatic dir_row_t checked_row(logic [ACT_W-1:0] act, int unsigned pg,
                                             int unsigned res, logic [STAT_W-1:0] st,
                                             logic fr);
        dir_row_t row;
        row = req_row(act, pg);
        row.typed = 1'b1;
        row.want.result_page = PAGE_W'(res);
        row.want.status = st;
        row.want.became_free = fr;
        return row;
    endfunction

    function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        dir_row_t row;
        row = '0;
        row.reg_write = 1'b1;
        row.reg_idx = idx;
        row.reg_val = CFG_W'(val);
        return row;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("ERROR: result %0d: %s is %0d, wanted %0d",
                     results_seen, field, got_v, want_v);
    endtask

    // Presents one request and returns once the transaction has been taken.
    task automatic send_request(input in_item_t req, input bit typed, input out_item_t given,
                                output out_item_t outcome);
        push <= 1'b1;
        in_item <= req;
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        outcome = allocator_outcome(req);
        awaited_outcomes.push_back(typed ? given : outcome);
        requests_sent++;
        if (req.action == ACT_INIT)
        begin
            init_count++;
            held_pages.delete();
        end
        if (req.action == ACT_ALLOC && outcome.status == ST_EMPTY)
            empty_allocs++;
        if (outcome.status == ST_UNREF)
            bad_frees++;
        if (outcome.became_free)
            pages_returned++;
    endtask

    task automatic drain_results(input int unsigned settle);
        push <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain_results(4);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TOTAL_PAGES)
            cfg_total = val;
        else
            cfg_kend = val;
    endtask

    initial
    begin : stimulus
        dir_row_t    script [$];
        in_item_t    req;
        out_item_t   outcome;
        int unsigned phase_total [PHASES];
        int unsigned phase_kend [PHASES];
        int unsigned lim;
        int unsigned near_top;
        int unsigned pick;
        int unsigned slot;
        int unsigned burst_left;
        int unsigned gap;
        int unsigned spare_inits;
        int unsigned n;
        int          ph;

        rst_n <= 1'b0;
        push <= 1'b0;
        in_item <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= '0;
        cfg_wdata <= '0;
        shadow_head = LIST_END;
        for (n = 0; n < MAX_PAGES; n++)
        begin
            shadow_link[n] = '0;
            shadow_refs[n] = '0;
        end
        cfg_total = TOTAL_PAGES_RST;
        cfg_kend = KERNEL_END_RST;

        // Reset register values first: the list head runs 9, 10, 11 and so on.
        script.push_back(checked_row(ACT_INIT, 16383, 0, ST_OK, 1'b0));
        script.push_back(checked_row(ACT_ALLOC, 0, 9, ST_OK, 1'b0));
        script.push_back(checked_row(ACT_ALLOC, 16383, 10, ST_OK, 1'b0));
        script.push_back(checked_row(ACT_FREE, 9, 0, ST_OK, 1'b1));
        script.push_back(checked_row(ACT_FREE, 9, 0, ST_UNREF, 1'b0));
        script.push_back(checked_row(ACT_ALLOC, 0, 9, ST_OK, 1'b0));
        // Reserved pages carry a count of one and join the list when freed.
        script.push_back(checked_row(ACT_FREE, 0, 0, ST_OK, 1'b1));
        script.push_back(checked_row(ACT_FREE, TRAMPOLINE_PAGE, 0, ST_OK, 1'b1));
        script.push_back(checked_row(ACT_FREE, 1023, 0, ST_OK, 1'b1));
        script.push_back(checked_row(ACT_FREE, 16383, 0, ST_UNREF, 1'b0));
        script.push_back(checked_row(ACT_UNDEF, 16383, 0, ST_OK, 1'b0));
        script.push_back(checked_row(ACT_ALLOC, 0, 1023, ST_OK, 1'b0));
        script.push_back(checked_row(ACT_ALLOC, 0, TRAMPOLINE_PAGE, ST_OK, 1'b0));
        script.push_back(checked_row(ACT_ALLOC, 0, 0, ST_OK, 1'b0));
        script.push_back(req_row(ACT_ALLOC, 5461));
        // With no managed pages the list stays empty and every free is out of range.
        script.push_back(reg_row(CFG_TOTAL_PAGES, 0));
        script.push_back(checked_row(ACT_INIT, 0, 0, ST_OK, 1'b0));
        script.push_back(checked_row(ACT_ALLOC, 10922, 0, ST_EMPTY, 1'b0));
        script.push_back(checked_row(ACT_FREE, 0, 0, ST_UNREF, 1'b0));
        // Five managed pages: only pages 1 to 4 reach the list.
        script.push_back(reg_row(CFG_TOTAL_PAGES, 5));
        script.push_back(checked_row(ACT_INIT, 0, 0, ST_OK, 1'b0));
        script.push_back(checked_row(ACT_ALLOC, 0, 1, ST_OK, 1'b0));
        script.push_back(checked_row(ACT_FREE, 4, 0, ST_UNREF, 1'b0));
        script.push_back(checked_row(ACT_FREE, 5, 0, ST_UNREF, 1'b0));
        script.push_back(reg_row(CFG_KERNEL_END, 16384));

        phase_total = '{200, 5, 16384, 0, 1100, 16383, 300};
        phase_kend  = '{160, 160, 16384, 200, 1024, 16383, 170};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            if (script[r].reg_write)
                write_reg(script[r].reg_idx, script[r].reg_val);
            else
                send_request(script[r].req, script[r].typed, script[r].want, outcome);
        end

        burst_left = 0;
        spare_inits = 10;
        for (ph = 0; ph < PHASES; ph++)
        begin
            write_reg(CFG_TOTAL_PAGES, CFG_W'(phase_total[ph]));
            write_reg(CFG_KERNEL_END, CFG_W'(phase_kend[ph]));
            req.action = ACT_INIT;
            req.page_index = PAGE_W'($urandom_range(0, MAX_PAGES - 1));
            send_request(req, 1'b0, '0, outcome);
            lim = managed_pages();
            near_top = (lim + 3 < MAX_PAGES) ? lim + 3 : MAX_PAGES - 1;
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    if (gap != 0)
                    begin
                        push <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 16);
                end
                burst_left--;

                pick = $urandom_range(0, 99);
                req.page_index = PAGE_W'($urandom_range(0, MAX_PAGES - 1));
                if (pick < 2 && spare_inits != 0)
                begin
                    req.action = ACT_INIT;
                    spare_inits--;
                end
                else if (pick < 5)
                    req.action = ACT_UNDEF;
                else if (pick < 13)
                begin
                    // Stray frees, half of them near the managed range so that
                    // reserved pages and the range boundary get hit.
                    req.action = ACT_FREE;
                    if (pick < 9)
                        req.page_index = PAGE_W'($urandom_range(0, near_top));
                end
                else if (pick < 55 && held_pages.size() != 0)
                begin
                    slot = $urandom_range(0, held_pages.size() - 1);
                    req.action = ACT_FREE;
                    req.page_index = PAGE_W'(held_pages[slot]);
                    held_pages.delete(slot);
                end
                else
                    req.action = ACT_ALLOC;

                send_request(req, 1'b0, '0, outcome);
                if (req.action == ACT_ALLOC && outcome.status == ST_OK)
                    held_pages.push_back(outcome.result_page);
                if (req.action != ACT_UNDEF)
                    n++;
            end
        end

        drain_results(20);
        $display("Ran %0d requests over %0d list rebuilds and %0d register settings; %0d results.",
                 requests_sent, init_count, PHASES + 1, results_seen);
        $display("Seen: %0d allocates on an empty list, %0d rejected frees, %0d pages returned.",
                 empty_allocs, bad_frees, pages_returned);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: checks each popped transaction and stalls on its own schedule.
    initial
    begin : result_sink
        out_item_t   want;
        sink_mode_t  mode;
        int unsigned mode_left;
        int unsigned tick;
        mode = SINK_STREAM;
        mode_left = 0;
        tick = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && empty === 1'b0)
            begin
                results_seen++;
                if (awaited_outcomes.size() == 0)
                    report_mismatch("result with no request outstanding, page",
                                    out_item.result_page, 0);
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (out_item.result_page !== want.result_page)
                        report_mismatch("result_page", out_item.result_page, want.result_page);
                    if (out_item.status !== want.status)
                        report_mismatch("status", out_item.status, want.status);
                    if (out_item.became_free !== want.became_free)
                        report_mismatch("became_free", out_item.became_free, want.became_free);
                end
            end
            if (mode_left == 0)
            begin
                mode = sink_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(8, 80);
            end
            mode_left--;
            tick++;
            case (mode)
                SINK_STREAM:   pop <= 1'b1;
                SINK_COIN:     pop <= 1'($urandom_range(0, 1));
                SINK_STARVE:   pop <= ($urandom_range(0, 5) == 0);
                SINK_PERIODIC: pop <= ((tick % 8) < 3);
                default:       pop <= 1'b1;
            endcase
        end
    end

    initial
    begin : watchdog
        #12_000_000;
        $display("TIMEOUT: %0d results still outstanding", awaited_outcomes.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
